// File: sv/sfrpt_pkg.sv
// Shared types and constants of the sync frame receiver / page transposer.
package sfrpt_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } opcode_e;

  localparam int unsigned SYNC_LEN    = 3;
  localparam logic [1:0]  SYNC_FULL   = 2'd3;
  localparam logic [7:0]  SYNC_BYTE0  = 8'hB0;
  localparam logic [7:0]  SYNC_BYTE1  = 8'h0F;
  localparam logic [7:0]  SYNC_BYTE2  = 8'h13;

  localparam int unsigned HEADER_SKIP = 3;
  localparam int unsigned LINE_STRIDE = 19;
  localparam int unsigned DISP_WIDTH  = 128;
  localparam int unsigned PAGES       = 8;
  localparam int unsigned COL_W       = $clog2(DISP_WIDTH);
  localparam int unsigned PAGE_W      = $clog2(PAGES);
  localparam int unsigned LINE_W      = PAGE_W + 3;
  // widest store offset a read can form: last column byte of the last line
  localparam int unsigned POS_MAX     = (DISP_WIDTH / 8 - 1) + HEADER_SKIP
                                        + (PAGES * 8 - 1) * LINE_STRIDE;
  localparam int unsigned POS_W       = $clog2(POS_MAX + 1);

  localparam logic [15:0] LIMIT_RESET = 16'd120;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = SYNC_BYTE0;
      2'd1:    b = SYNC_BYTE1;
      default: b = SYNC_BYTE2;
    endcase
    return b;
  endfunction

endpackage

// File: sv/sfrpt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module sfrpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1216
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/sync_frame_receiver_page_transposer.sv
// Sync frame receiver with frame store and page-format display read-out.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: opcode[1:0]; tdata: data_byte[7:0], display_index[17:8]
//  m_axis    out        tdata: display_byte[7:0]; tlast: frame_complete;
//                       tuser: store_cleared, synced
//  cfg       in         cfg_data_i: timeout_limit[15:0]
//
// Serial byte, tick and unused opcode: run in EXEC, result registered from DONE.
// Display read: eight store reads on the single RAM read port, then DRAIN, DONE.
// A high-water mark tracks which store entries hold data since the last
// blanking, so reset and timeout blank the store at once, with no sweep.
// The next item is taken while a finished result waits on m_axis.
module sync_frame_receiver_page_transposer
  import sfrpt_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 1216
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte[7:0], display_index[17:8], zero pad
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // display_byte[7:0]
  output logic        m_axis_tlast,   // frame_complete
  output logic [1:0]  m_axis_tuser,   // store_cleared, synced
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned PW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] FRAME_END = PW'(FRAME_BYTES);
  localparam logic [PW-1:0] WP_START  = PW'(HEADER_SKIP);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [1:0]  op_q;
  logic [7:0]  byte_q;
  logic [9:0]  idx_q;
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] hw_q, hw_d;     // entries below this hold data since last blanking
  logic [1:0]  sync_q, sync_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] limit_q;
  logic [2:0]  p_q, p_d;
  logic        rtn_v_q, rtn_ok_q;
  logic [2:0]  rtn_p_q;
  logic [7:0]  acc_q, acc_d;
  logic        res_done_q, res_done_d;
  logic        res_clr_q, res_clr_d;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;
  logic [1:0]  out_user_q;

  logic        in_xfer, out_free, issue;
  logic [15:0] tick_inc;
  logic [PW-1:0] wp_inc;
  logic [LINE_W-1:0] line;
  logic [CW-1:0] rd_pos;
  logic        rd_ok;
  logic        mem_we;
  logic [7:0]  mem_rdata;
  logic [COL_W-1:0] col;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign col      = idx_q[COL_W-1:0];
  assign line     = {idx_q[PAGE_W+COL_W-1:COL_W], p_q};
  assign rd_pos   = CW'(col[COL_W-1:3]) + CW'(HEADER_SKIP)
                    + CW'(line) * CW'(LINE_STRIDE);
  assign rd_ok    = (rd_pos < CW'(FRAME_BYTES)) && (rd_pos < CW'(hw_q));
  assign issue    = (state_q == ST_READ);
  assign tick_inc = tick_q + 16'd1;
  assign wp_inc   = wp_q + PW'(1);
  assign mem_we   = (state_q == ST_EXEC) && (op_q == OP_BYTE)
                    && (sync_q == SYNC_FULL) && (wp_q < FRAME_END);

  sfrpt_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wp_q[AW-1:0]),
    .wdata_i(byte_q),
    .raddr_i(rd_pos[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    hw_d       = hw_q;
    sync_d     = sync_q;
    tick_d     = tick_q;
    p_d        = p_q;
    acc_d      = acc_q;
    res_done_d = res_done_q;
    res_clr_d  = res_clr_q;

    if (rtn_v_q && rtn_ok_q && mem_rdata[col[2:0]]) begin
      acc_d[rtn_p_q] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          acc_d      = '0;
          res_done_d = 1'b0;
          res_clr_d  = 1'b0;
          p_d        = '0;
          state_d    = (s_axis_tuser == OP_READ) ? ST_READ : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (op_q)
          OP_BYTE: begin
            if (sync_q != SYNC_FULL) begin
              if (byte_q == sync_byte(sync_q)) begin
                sync_d = sync_q + 2'd1;
              end else if (sync_q != 2'd0) begin
                sync_d = sync_q - 2'd1;
              end
            end else begin
              wp_d = wp_inc;
              if (wp_inc > hw_q && wp_q < FRAME_END) begin
                hw_d = wp_inc;
              end
              if (wp_inc >= FRAME_END) begin
                wp_d       = WP_START;
                sync_d     = 2'd0;
                tick_d     = '0;
                res_done_d = 1'b1;
              end
            end
          end
          OP_TICK: begin
            tick_d = tick_inc;
            if (tick_inc > limit_q) begin
              // blanking: forget every stored entry
              hw_d      = WP_START;
              wp_d      = WP_START;
              sync_d    = 2'd0;
              tick_d    = '0;
              res_clr_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_READ: begin
        p_d = p_q + 3'd1;
        if (p_q == 3'd7) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= WP_START;
      hw_q        <= WP_START;
      sync_q      <= 2'd0;
      tick_q      <= '0;
      limit_q     <= LIMIT_RESET;
      rtn_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      hw_q    <= hw_d;
      sync_q  <= sync_d;
      tick_q  <= tick_d;
      rtn_v_q <= issue;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= s_axis_tuser;
      byte_q <= s_axis_tdata[7:0];
      idx_q  <= s_axis_tdata[17:8];
    end
    p_q        <= p_d;
    acc_q      <= acc_d;
    res_done_q <= res_done_d;
    res_clr_q  <= res_clr_d;
    rtn_p_q    <= p_q;
    rtn_ok_q   <= rd_ok;
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= acc_q;
      out_last_q <= res_done_q;
      out_user_q <= {sync_q == SYNC_FULL, res_clr_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

`ifndef NO_ASSERTIONS
  a_hw_covers_wp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q >= wp_q)
    else $error("write position ran past the filled region");

  a_hw_in_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= FRAME_END)
    else $error("fill mark beyond the store");

  a_clear_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (!m_axis_tuser[1] && !m_axis_tlast))
    else $error("blanking result reports sync or frame end");

  a_read_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !mem_we)
    else $error("store written during a display read");
`endif

endmodule

// File: tb/tb_sync_frame_receiver_page_transposer.sv
`timescale 1ns / 1ps
// Self-checking testbench: sync hunt, frame fill, timeout blanking and page reads vs. predictor.
module tb_sync_frame_receiver_page_transposer;
  import sfrpt_pkg::*;

  localparam int unsigned FRAME_BYTES  = 1216;
  localparam int unsigned RESET_CYCLES = 11;
  // worst quiet stretch: receiver hold-off plus a long sender gap; far below this
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 145;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [15:0] LIMIT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] disp;
    logic       done;
    logic       cleared;
    logic       synced;
  } rx_result_t;

  localparam rx_result_t R_NONE = '0;
  localparam rx_result_t R_SYNC = '{disp: 8'h00, done: 1'b0, cleared: 1'b0, synced: 1'b1};
  localparam rx_result_t R_CLR  = '{disp: 8'h00, done: 1'b0, cleared: 1'b1, synced: 1'b0};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  op;
    logic [7:0]  data;
    logic [9:0]  idx;
    logic [15:0] limit;
    logic        typed;
    rx_result_t  want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_ITEM, OP_READ,   8'h00, 10'd0,    16'd0,     1'b1, R_NONE}, // blank store
    '{ROW_ITEM, OP_READ,   8'h00, 10'd1023, 16'd0,     1'b1, R_NONE}, // last page, last column
    '{ROW_ITEM, OP_UNUSED, 8'hFF, 10'd1023, 16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_TICK,   8'h00, 10'd0,    16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_BYTE,   8'h00, 10'd0,    16'd0,     1'b1, R_NONE}, // miss with count at zero
    '{ROW_ITEM, OP_BYTE,   8'hB0, 10'd0,    16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_BYTE,   8'hFF, 10'd0,    16'd0,     1'b1, R_NONE}, // steps count back
    '{ROW_ITEM, OP_BYTE,   8'hB0, 10'd0,    16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_BYTE,   8'h0F, 10'd0,    16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_BYTE,   8'h13, 10'd0,    16'd0,     1'b1, R_SYNC},
    '{ROW_ITEM, OP_UNUSED, 8'h00, 10'd0,    16'd0,     1'b1, R_SYNC}, // reports current sync
    '{ROW_ITEM, OP_BYTE,   8'hFF, 10'd0,    16'd0,     1'b1, R_SYNC},
    '{ROW_ITEM, OP_BYTE,   8'h80, 10'd0,    16'd0,     1'b0, R_NONE},
    '{ROW_ITEM, OP_TICK,   8'h00, 10'd0,    16'd0,     1'b1, R_SYNC},
    '{ROW_ITEM, OP_READ,   8'h00, 10'd0,    16'd0,     1'b0, R_NONE},
    '{ROW_ITEM, OP_READ,   8'h00, 10'd15,   16'd0,     1'b0, R_NONE},
    '{ROW_CFG,  OP_BYTE,   8'h00, 10'd0,    16'd0,     1'b0, R_NONE}, // every tick blanks
    '{ROW_ITEM, OP_TICK,   8'h00, 10'd0,    16'd0,     1'b1, R_CLR},
    '{ROW_ITEM, OP_READ,   8'h00, 10'd0,    16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_BYTE,   8'hB0, 10'd0,    16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_BYTE,   8'h0F, 10'd0,    16'd0,     1'b1, R_NONE},
    '{ROW_ITEM, OP_BYTE,   8'h13, 10'd0,    16'd0,     1'b1, R_SYNC},
    '{ROW_ITEM, OP_BYTE,   8'h01, 10'd0,    16'd0,     1'b1, R_SYNC},
    '{ROW_ITEM, OP_READ,   8'h00, 10'd0,    16'd0,     1'b0, R_NONE}, // written at offset 3
    '{ROW_CFG,  OP_BYTE,   8'h00, 10'd0,    LIMIT_MAX, 1'b0, R_NONE},
    '{ROW_ITEM, OP_TICK,   8'h00, 10'd0,    16'd0,     1'b1, R_SYNC}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  sync_frame_receiver_page_transposer #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // data_byte[7:0], display_index[17:8], zero pad
    .s_axis_tuser (s_axis_tuser),   // opcode[1:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // display_byte[7:0]
    .m_axis_tlast (m_axis_tlast),   // frame_complete
    .m_axis_tuser (m_axis_tuser),   // store_cleared, synced
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the receiver state
  logic [7:0]  rx_store [FRAME_BYTES];
  int unsigned rx_wr_pos;
  int unsigned rx_sync;
  logic [15:0] rx_ticks;
  logic [15:0] rx_limit;
  logic [7:0]  sync_pattern [SYNC_LEN] = '{SYNC_BYTE0, SYNC_BYTE1, SYNC_BYTE2};

  rx_result_t  due_results [$];
  rx_result_t  seen_result;
  rx_result_t  want_result;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned tx_idle_pct = 20;
  int unsigned rx_idle_pct = 86;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic void restart_hunt();
    rx_wr_pos = HEADER_SKIP;
    rx_sync   = 0;
    rx_ticks  = '0;
  endfunction

  function automatic rx_result_t frame_rx_step(logic [1:0] op, logic [7:0] data,
                                               logic [9:0] idx);
    rx_result_t  res;
    int unsigned page;
    int unsigned col;
    int unsigned pos;
    res = R_NONE;
    case (op)
      OP_BYTE: begin
        if (rx_sync < SYNC_LEN) begin
          if (data == sync_pattern[rx_sync]) rx_sync++;
          else if (rx_sync > 0) rx_sync--;
        end else begin
          if (rx_wr_pos < FRAME_BYTES) rx_store[rx_wr_pos] = data;
          rx_wr_pos++;
          if (rx_wr_pos >= FRAME_BYTES) begin
            restart_hunt();
            res.done = 1'b1;
          end
        end
      end
      OP_TICK: begin
        rx_ticks = rx_ticks + 16'd1;  // wraps at 16 bits
        if (rx_ticks > rx_limit) begin
          foreach (rx_store[i]) rx_store[i] = '0;
          restart_hunt();
          res.cleared = 1'b1;
        end
      end
      OP_READ: begin
        page = idx / DISP_WIDTH;
        col  = idx % DISP_WIDTH;
        if (page < PAGES) begin
          for (int p = 0; p < 8; p++) begin
            pos = col / 8 + HEADER_SKIP + (page * 8 + p) * LINE_STRIDE;
            if (pos < FRAME_BYTES) res.disp[p] = rx_store[pos][col % 8];
          end
        end
      end
      default: ;
    endcase
    res.synced = (rx_sync == SYNC_LEN);
    return res;
  endfunction

  // Valid stays up across back-to-back transfers; it only drops on a gap.
  task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                           input logic [9:0] idx, input bit typed = 1'b0,
                           input rx_result_t want = R_NONE);
    rx_result_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, idx, data};
    do @(posedge clk_i); while (!s_axis_tready);
    got = frame_rx_step(op, data, idx);
    due_results.push_back(typed ? want : got);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic write_limit(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rx_limit = value;
  endtask

  // half the reads aim at the first two pages, where short bursts land
  function automatic logic [9:0] read_index();
    return $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(255));
  endfunction

  task automatic sync_up();
    while (rx_sync < SYNC_LEN) send_item(OP_BYTE, sync_pattern[rx_sync], 10'($urandom));
  endtask

  task automatic run_episode();
    int unsigned kind;
    int unsigned n;
    int unsigned roll;
    kind = $urandom_range(9);
    if (kind < 5) begin
      // sync, then a burst of line data with reads, ticks and unused opcodes mixed in
      sync_up();
      n = $urandom_range(1, 48);
      repeat (n) begin
        roll = $urandom_range(99);
        if (roll < 70) send_item(OP_BYTE, 8'($urandom), 10'($urandom));
        else if (roll < 88) send_item(OP_READ, 8'($urandom), read_index());
        else if (roll < 95) send_item(OP_TICK, 8'($urandom), 10'($urandom));
        else send_item(OP_UNUSED, 8'($urandom), 10'($urandom));
      end
    end else if (kind < 7) begin
      // broken sync: a correct prefix, then an arbitrary byte
      n = $urandom_range(0, SYNC_LEN - 1);
      for (int k = 0; k < n; k++) send_item(OP_BYTE, sync_pattern[k], 10'($urandom));
      send_item(OP_BYTE, 8'($urandom), 10'($urandom));
    end else if (kind == 7) begin
      repeat ($urandom_range(4, 16)) send_item(OP_READ, 8'($urandom), read_index());
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 8)) send_item(OP_TICK, 8'($urandom), 10'($urandom));
    end else begin
      repeat (8) send_item(2'($urandom), 8'($urandom), 10'($urandom));
    end
  endtask

  // Result side: checks each transfer, then picks the next ready level.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_result = '{disp: m_axis_tdata, done: m_axis_tlast,
                        cleared: m_axis_tuser[0], synced: m_axis_tuser[1]};
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result: byte=%02h done=%0b clr=%0b sync=%0b",
                     seen_result.disp, seen_result.done, seen_result.cleared,
                     seen_result.synced);
        end else begin
          want_result = due_results.pop_front();
          if (seen_result !== want_result) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: expected byte=%02h done=%0b clr=%0b sync=%0b, %s",
                       want_result.disp, want_result.done, want_result.cleared,
                       want_result.synced,
                       $sformatf("got byte=%02h done=%0b clr=%0b sync=%0b",
                                 seen_result.disp, seen_result.done,
                                 seen_result.cleared, seen_result.synced));
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen     <= hold_reqs;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (rx_store[i]) rx_store[i] = '0;
    restart_hunt();
    rx_limit  = LIMIT_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) write_limit(directed_rows[r].limit);
      else send_item(directed_rows[r].op, directed_rows[r].data, directed_rows[r].idx,
                     directed_rows[r].typed, directed_rows[r].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 86 : 0;
      rx_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 20 : 0;
      case (ph)
        0:       write_limit(16'd0);
        1, 5:    write_limit(LIMIT_MAX);
        2:       write_limit(16'($urandom_range(1, 12)));
        3:       write_limit(LIMIT_RESET);
        default: write_limit(16'($urandom_range(0, 40)));
      endcase
      // long receiver hold-off while items keep coming: input must back up
      if (ph == 2 || ph == 5) hold_reqs <= hold_reqs + 1;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) run_episode();
    end

    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/sfrpt_pkg.sv
sv/sfrpt_ram.sv
sv/sync_frame_receiver_page_transposer.sv
tb/tb_sync_frame_receiver_page_transposer.sv
